// ----- rtl/core/ssfh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ssfh_pkg;

    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = 5;
    localparam int CNT_W = 16;
    localparam int SUM_W = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_NO_FRAMES = 2'd2;

    localparam logic [1:0] REG_BIN_WIDTH = 2'd0;
    localparam logic [1:0] REG_BOTTOM    = 2'd1;
    localparam logic [1:0] REG_TOP       = 2'd2;
    localparam logic [1:0] REG_BINS      = 2'd3;

    localparam logic [23:0] RST_BIN_WIDTH = 24'd256;
    localparam logic [23:0] RST_BOTTOM    = 24'd0;
    localparam logic [23:0] RST_TOP       = 24'hFFFFFF;
    localparam logic [6:0]  RST_BINS      = 7'd64;

    localparam logic [1:0] SP_POLY = 2'd0;
    localparam logic [1:0] SP_SOLV = 2'd1;

    typedef enum logic [1:0] {
        REQ_PART  = 2'd0,
        REQ_FRAME = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        DSEL_BIN    = 3'd0,
        DSEL_FRAC   = 3'd1,
        DSEL_MEAN   = 3'd2,
        DSEL_TOP    = 3'd3,
        DSEL_MEAN_T = 3'd4
    } t_div_sel;

    typedef enum logic [18:0] {
        S_CLEAR    = 19'd1 << 0,
        S_IDLE     = 19'd1 << 1,
        S_DISP     = 19'd1 << 2,
        S_BIN_GO   = 19'd1 << 3,
        S_BIN_WAIT = 19'd1 << 4,
        S_CNT_RD   = 19'd1 << 5,
        S_CNT_WR   = 19'd1 << 6,
        S_FR_RD    = 19'd1 << 7,
        S_FB_GO    = 19'd1 << 8,
        S_FB_WAIT  = 19'd1 << 9,
        S_FT_GO    = 19'd1 << 10,
        S_FT_WAIT  = 19'd1 << 11,
        S_FR_WR    = 19'd1 << 12,
        S_RD_RD    = 19'd1 << 13,
        S_MB_GO    = 19'd1 << 14,
        S_MB_WAIT  = 19'd1 << 15,
        S_MT_GO    = 19'd1 << 16,
        S_MT_WAIT  = 19'd1 << 17,
        S_DONE     = 19'd1 << 18
    } t_state;

    typedef struct packed {
        logic     in_ready;
        logic     div_start;
        t_div_sel div_sel;
        logic     save_b;
        logic     save_t;
        logic     cnt_rd;
        logic     cnt_inc;
        logic     walk_rd;
        logic     walk_wr;
        logic     clr_wr;
        logic     rd_rd;
        logic     set_drop;
        logic     set_nofr;
        logic     frame_inc;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        t_req req;
        logic div_done;
        logic div_busy;
        logic bin_ok;
        logic last_idx;
        logic frames_zero;
        logic rb_ok;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/core/ssfh_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssfh_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ssfh_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [ssfh_pkg::DIV_W-1:0] i_divisor,
    output logic      [ssfh_pkg::DIV_W-1:0] o_quotient,
    output logic                           o_busy,
    output logic                           o_done
);
    import ssfh_pkg::*;

    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [DIV_W:0]       sh;
    logic [DIV_W:0]       diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        sh    = {r_rem, r_quo[DIV_W-1]};
        diff  = sh - {1'b0, r_den};
        if (sh >= {1'b0, r_den}) begin
            n_rem = diff[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = sh[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;
endmodule
`default_nettype wire

// ----- rtl/core/ssfh_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssfh_dp #(
    parameter int MAX_BINS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ssfh_pkg::t_cmd i_cmd,
    output ssfh_pkg::t_sts      o_sts,
    input  wire logic [23:0]   i_bin_width,
    input  wire logic [23:0]   i_bottom_surface,
    input  wire logic [23:0]   i_top_surface,
    input  wire logic [6:0]    i_bins_in_use,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [23:0]   i_x_pos,
    input  wire logic [23:0]   i_z_pos,
    input  wire logic [1:0]    i_species,
    input  wire logic [5:0]    i_read_bin,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [15:0]        o_mean_bottom,
    output logic [15:0]        o_mean_top,
    output logic [15:0]        o_frames_done
);
    import ssfh_pkg::*;

    localparam int AW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int CW  = (NBW > 7) ? NBW : 7;

    logic [4*CNT_W-1:0] r_cnt_mem [MAX_BINS];
    logic [2*SUM_W-1:0] r_sum_mem [MAX_BINS];
    logic [4*CNT_W-1:0] r_cnt_q;
    logic [2*SUM_W-1:0] r_sum_q;

    logic [1:0]   r_req, r_sp;
    logic [23:0]  r_x, r_z;
    logic [5:0]   r_rb;
    logic [AW-1:0] r_idx;
    logic [15:0]  r_fb, r_ft;
    logic [1:0]   r_status;
    logic [15:0]  r_frames;
    logic         r_ovalid;
    logic [1:0]   r_ostatus;
    logic [15:0]  r_omb, r_omt, r_ofr;

    logic [23:0]    w;
    logic [CW-1:0]  nb;
    logic           in_fire;
    logic           div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_a, div_b, quo;
    logic [15:0]    q_sat;
    logic [AW-1:0]  bin_addr, rd_addr, cnt_addr;
    logic [CNT_W-1:0] pb, sb, pt, st;
    logic [SUM_W-1:0] sum_b, sum_t;
    logic [24:0]    bot_hi, z_hi;
    logic           in_bot, in_top, idx_used;
    logic [CNT_W-1:0] n_pb, n_sb, n_pt, n_st;
    logic [SUM_W:0] add_b, add_t;
    logic [SUM_W-1:0] n_sum_b, n_sum_t;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    assign w = (i_bin_width == '0) ? 24'd1 : i_bin_width;

    always_comb begin
        if (i_bins_in_use == '0)
            nb = CW'(1);
        else if (CW'(i_bins_in_use) > CW'(MAX_BINS))
            nb = CW'(MAX_BINS);
        else
            nb = CW'(i_bins_in_use);
    end

    assign in_fire = i_cmd.in_ready & i_valid;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_req_type;
            r_x   <= i_x_pos;
            r_z   <= i_z_pos;
            r_sp  <= i_species;
            r_rb  <= i_read_bin;
        end
    end

    assign {pb, sb, pt, st} = r_cnt_q;
    assign {sum_b, sum_t}   = r_sum_q;

    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_BIN: begin
                div_a = DIV_W'(r_x);
                div_b = DIV_W'(w);
            end
            DSEL_FRAC: begin
                div_a = {pb, 16'd0};
                div_b = DIV_W'(pb) + DIV_W'(sb);
            end
            DSEL_TOP: begin
                div_a = {pt, 16'd0};
                div_b = DIV_W'(pt) + DIV_W'(st);
            end
            DSEL_MEAN: begin
                div_a = sum_b;
                div_b = DIV_W'(r_frames);
            end
            DSEL_MEAN_T: begin
                div_a = sum_t;
                div_b = DIV_W'(r_frames);
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    assign div_start = i_cmd.div_start;

    ssfh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quotient (quo),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    assign q_sat = (|quo[DIV_W-1:16]) ? 16'hFFFF : quo[15:0];

    assign bin_addr = quo[AW-1:0];
    assign rd_addr  = AW'(r_rb);
    assign cnt_addr = i_cmd.cnt_rd ? bin_addr : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd || i_cmd.walk_rd)
            r_cnt_q <= r_cnt_mem[cnt_addr];
        if (i_cmd.walk_rd)
            r_sum_q <= r_sum_mem[r_idx];
        else if (i_cmd.rd_rd)
            r_sum_q <= r_sum_mem[rd_addr];
    end

    assign bot_hi = {1'b0, i_bottom_surface} + {1'b0, w};
    assign z_hi   = {1'b0, r_z} + {1'b0, w};
    assign in_bot = (r_z >= i_bottom_surface) && ({1'b0, r_z} < bot_hi);
    assign in_top = (r_z <= i_top_surface) && (z_hi > {1'b0, i_top_surface});

    always_comb begin
        n_pb = pb;
        n_sb = sb;
        n_pt = pt;
        n_st = st;
        if (in_bot) begin
            if (r_sp == SP_POLY) n_pb = inc_sat(pb);
            else if (r_sp == SP_SOLV) n_sb = inc_sat(sb);
        end else if (in_top) begin
            if (r_sp == SP_POLY) n_pt = inc_sat(pt);
            else if (r_sp == SP_SOLV) n_st = inc_sat(st);
        end
    end

    assign add_b = {1'b0, sum_b} + (SUM_W + 1)'(r_fb);
    assign add_t = {1'b0, sum_t} + (SUM_W + 1)'(r_ft);
    assign n_sum_b = ((pb | sb) == '0) ? sum_b : (add_b[SUM_W] ? '1 : add_b[SUM_W-1:0]);
    assign n_sum_t = ((pt | st) == '0) ? sum_t : (add_t[SUM_W] ? '1 : add_t[SUM_W-1:0]);
    assign idx_used = CW'(r_idx) < nb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_inc)
            r_cnt_mem[bin_addr] <= {n_pb, n_sb, n_pt, n_st};
        else if (i_cmd.walk_wr || i_cmd.clr_wr)
            r_cnt_mem[r_idx] <= '0;
        if (i_cmd.clr_wr)
            r_sum_mem[r_idx] <= '0;
        else if (i_cmd.walk_wr && idx_used)
            r_sum_mem[r_idx] <= {n_sum_b, n_sum_t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_frames <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_fire)
                r_idx <= '0;
            else if (i_cmd.walk_wr || i_cmd.clr_wr)
                r_idx <= (r_idx == AW'(MAX_BINS - 1)) ? '0 : r_idx + 1'b1;
            if (i_cmd.frame_inc && r_frames != '1)
                r_frames <= r_frames + 1'b1;
            if (i_cmd.load_out)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= ST_OK;
            r_fb     <= '0;
            r_ft     <= '0;
        end else begin
            if (i_cmd.set_drop) r_status <= ST_DROPPED;
            if (i_cmd.set_nofr) r_status <= ST_NO_FRAMES;
            if (i_cmd.save_b)   r_fb <= q_sat;
            if (i_cmd.save_t)   r_ft <= q_sat;
        end
        if (i_cmd.load_out) begin
            r_ostatus <= r_status;
            r_omb     <= (r_req == REQ_READ) ? r_fb : '0;
            r_omt     <= (r_req == REQ_READ) ? r_ft : '0;
            r_ofr     <= r_frames;
        end
    end

    always_comb begin
        o_sts.in_fire     = in_fire;
        o_sts.req         = t_req'(r_req);
        o_sts.div_done    = div_done;
        o_sts.div_busy    = div_busy;
        o_sts.bin_ok      = quo < DIV_W'(nb);
        o_sts.last_idx    = r_idx == AW'(MAX_BINS - 1);
        o_sts.frames_zero = r_frames == '0;
        o_sts.rb_ok       = CW'(r_rb) < nb;
        o_sts.out_free    = !r_ovalid || i_ready;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_mean_bottom = r_omb;
    assign o_mean_top    = r_omt;
    assign o_frames_done = r_ofr;
endmodule
`default_nettype wire

// ----- rtl/core/ssfh_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssfh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ssfh_pkg::t_sts i_sts,
    output ssfh_pkg::t_cmd      o_cmd
);
    import ssfh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.last_idx) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire) n_state = S_DISP;
            end
            S_DISP: begin
                unique case (i_sts.req)
                    REQ_PART:  n_state = S_BIN_GO;
                    REQ_FRAME: n_state = S_FR_RD;
                    REQ_READ: begin
                        if (i_sts.frames_zero) begin
                            o_cmd.set_nofr = 1'b1;
                            n_state = S_DONE;
                        end else if (i_sts.rb_ok) begin
                            n_state = S_RD_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_BIN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_BIN;
                n_state = S_BIN_WAIT;
            end
            S_BIN_WAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.bin_ok) begin
                        n_state = S_CNT_RD;
                    end else begin
                        o_cmd.set_drop = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.cnt_inc = 1'b1;
                n_state = S_DONE;
            end
            S_FR_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = S_FB_GO;
            end
            S_FB_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_FRAC;
                n_state = S_FB_WAIT;
            end
            S_FB_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_b = 1'b1;
                    n_state = S_FT_GO;
                end
            end
            S_FT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_TOP;
                n_state = S_FT_WAIT;
            end
            S_FT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_t = 1'b1;
                    n_state = S_FR_WR;
                end
            end
            S_FR_WR: begin
                o_cmd.walk_wr = 1'b1;
                if (i_sts.last_idx) begin
                    o_cmd.frame_inc = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FR_RD;
                end
            end
            S_RD_RD: begin
                o_cmd.rd_rd = 1'b1;
                n_state = S_MB_GO;
            end
            S_MB_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_MEAN;
                n_state = S_MB_WAIT;
            end
            S_MB_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_b = 1'b1;
                    n_state = S_MT_GO;
                end
            end
            S_MT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_MEAN_T;
                n_state = S_MT_WAIT;
            end
            S_MT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_t = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/slab_species_fraction_histogram.sv -----
// A particle request runs one bin division, a read request two mean divisions and end of
// frame two fraction divisions per bin, all on the shared radix-2 divider. One request is
// in flight at a time; o_ready is raised again in the cycle after the result is loaded.
// Reset: synchronous, active low; a clearing pass over all MAX_BINS addresses zeroes the
// count and sum memories, with o_ready low, before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none
module slab_species_fraction_histogram #(
    parameter int MAX_BINS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [23:0] i_x_pos,
    input  wire logic [23:0] i_z_pos,
    input  wire logic [1:0]  i_species,
    input  wire logic [5:0]  i_read_bin,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_mean_bottom,
    output logic [15:0]      o_mean_top,
    output logic [15:0]      o_frames_done
);
    import ssfh_pkg::*;

    logic [23:0] r_bin_width, r_bottom, r_top;
    logic [6:0]  r_bins;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= RST_BIN_WIDTH;
            r_bottom    <= RST_BOTTOM;
            r_top       <= RST_TOP;
            r_bins      <= RST_BINS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BIN_WIDTH: r_bin_width <= pwdata[23:0];
                REG_BOTTOM:    r_bottom    <= pwdata[23:0];
                REG_TOP:       r_top       <= pwdata[23:0];
                REG_BINS:      r_bins      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BIN_WIDTH: prdata = {8'd0, r_bin_width};
            REG_BOTTOM:    prdata = {8'd0, r_bottom};
            REG_TOP:       prdata = {8'd0, r_top};
            REG_BINS:      prdata = {25'd0, r_bins};
            default:       prdata = '0;
        endcase
    end

    ssfh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ssfh_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_bin_width      (r_bin_width),
        .i_bottom_surface (r_bottom),
        .i_top_surface    (r_top),
        .i_bins_in_use    (r_bins),
        .i_valid          (i_valid),
        .i_req_type       (i_req_type),
        .i_x_pos          (i_x_pos),
        .i_z_pos          (i_z_pos),
        .i_species        (i_species),
        .i_read_bin       (i_read_bin),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_mean_bottom    (o_mean_bottom),
        .o_mean_top       (o_mean_top),
        .o_frames_done    (o_frames_done)
    );

    assign o_ready = cmd.in_ready;

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.in_ready |-> !sts.div_busy)
        else $error("divider busy while taking a request");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output or ready active right after reset");
endmodule
`default_nettype wire
